// ===== hw/rtl/bezier_path_mover_assert.svh =====
// Assertion macros shared by the bezier path mover RTL.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef BEZIER_PATH_MOVER_ASSERT_SVH
`define BEZIER_PATH_MOVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bpm_pkg.sv =====
`timescale 1ns / 1ps

package bpm_pkg;

  localparam int POS_W       = 24;
  localparam int T_FRAC_BITS = 16;
  localparam int PHASE_W     = T_FRAC_BITS + 1;
  localparam int PROD_W      = PHASE_W + 1 + POS_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int PT_W        = ACC_W - T_FRAC_BITS;
  localparam int SAT_W       = 32;

  localparam logic [PHASE_W-1:0]      T_ONE    = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (T_FRAC_BITS - 1);
  localparam logic signed [SAT_W-1:0] POS_MAX  = SAT_W'((64'sd1 <<< (POS_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] POS_MIN  = -SAT_W'(64'sd1 <<< (POS_W - 1));

  localparam logic OP_START  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    REG_C1_X,
    REG_C1_Y,
    REG_C2_X,
    REG_C2_Y,
    REG_END_X,
    REG_END_Y,
    REG_ABS_MODE
  } bpm_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_TT,
    ST_TU,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_X1,
    ST_X2,
    ST_X3,
    ST_Y1,
    ST_Y2,
    ST_Y3,
    ST_SUM,
    ST_OUT
  } bpm_state_t;

  typedef struct packed {
    logic                     op;
    logic [PHASE_W-1:0]       phase;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
  } bpm_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
  } bpm_result_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  c1_x;
    logic signed [POS_W-1:0]  c1_y;
    logic signed [POS_W-1:0]  c2_x;
    logic signed [POS_W-1:0]  c2_y;
    logic signed [POS_W-1:0]  end_x;
    logic signed [POS_W-1:0]  end_y;
    logic                     absolute_mode;
  } bpm_cfg_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
    if (v > POS_MAX) begin
      return POS_MAX[POS_W-1:0];
    end else if (v < POS_MIN) begin
      return POS_MIN[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/bpm_apb_regs.sv =====
`timescale 1ns / 1ps

module bpm_apb_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output bpm_pkg::bpm_cfg_t cfg
);
  import bpm_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_C1_X:     cfg.c1_x          <= pwdata[POS_W-1:0];
        REG_C1_Y:     cfg.c1_y          <= pwdata[POS_W-1:0];
        REG_C2_X:     cfg.c2_x          <= pwdata[POS_W-1:0];
        REG_C2_Y:     cfg.c2_y          <= pwdata[POS_W-1:0];
        REG_END_X:    cfg.end_x         <= pwdata[POS_W-1:0];
        REG_END_Y:    cfg.end_y         <= pwdata[POS_W-1:0];
        REG_ABS_MODE: cfg.absolute_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_C1_X:     prdata = 32'(cfg.c1_x);
      REG_C1_Y:     prdata = 32'(cfg.c1_y);
      REG_C2_X:     prdata = 32'(cfg.c2_x);
      REG_C2_Y:     prdata = 32'(cfg.c2_y);
      REG_END_X:    prdata = 32'(cfg.end_x);
      REG_END_Y:    prdata = 32'(cfg.end_y);
      REG_ABS_MODE: prdata = {31'd0, cfg.absolute_mode};
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/bezier_path_mover.sv =====
`timescale 1ns / 1ps
// An update transfer steps through the states TT, TU, W1-W3, X1-X3, Y1-Y3 and SUM, a start
// transfer through START; both then wait in OUT until the result register is free.
// The block takes no new item until it is back in IDLE; the update sequence is set
// by the single shared 18x24 multiplier, which forms all eleven products of an update.
// Reset (synchronous, active high) clears the registers, origin, last position and
// relative points to zero and leaves the block idle with no result pending.

`include "bezier_path_mover_assert.svh"

module bezier_path_mover (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  bpm_pkg::bpm_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output bpm_pkg::bpm_result_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bpm_pkg::*;

  bpm_cfg_t   cfg;
  bpm_state_t state, state_next;

  logic                     op_q;
  logic [PHASE_W-1:0]       t_q, u_q;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
  logic [PHASE_W-1:0]       tt, tu3, w1, w2, w3;
  logic signed [ACC_W-1:0]  acc_x, acc_y;
  logic signed [POS_W-1:0]  res_x, res_y;
  logic signed [POS_W-1:0]  origin_x, origin_y, last_x, last_y;
  logic signed [POS_W-1:0]  rel_c1_x, rel_c1_y, rel_c2_x, rel_c2_y, rel_end_x, rel_end_y;

  logic [PHASE_W-1:0]       mul_a;
  logic signed [POS_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PHASE_W-1:0]       wt;
  logic signed [ACC_W-1:0]  rnd_x, rnd_y;
  logic signed [PT_W-1:0]   pt_x, pt_y;
  logic signed [POS_W-1:0]  off_x, off_y;
  logic                     accept, out_free, load_out;

  bpm_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign u_q   = T_ONE - t_q;
  assign prod  = $signed({1'b0, mul_a}) * mul_b;
  assign wt    = prod[T_FRAC_BITS +: PHASE_W];
  assign rnd_x = acc_x + RND_HALF;
  assign rnd_y = acc_y + RND_HALF;
  assign pt_x  = PT_W'(rnd_x >>> T_FRAC_BITS);
  assign pt_y  = PT_W'(rnd_y >>> T_FRAC_BITS);
  assign off_x = cfg.absolute_mode ? pos_x_q : '0;
  assign off_y = cfg.absolute_mode ? pos_y_q : '0;

  always_comb begin
    unique case (state)
      ST_IDLE:  state_next = accept ? ((item.op == OP_START) ? ST_START : ST_TT) : ST_IDLE;
      ST_START: state_next = ST_OUT;
      ST_TT:    state_next = ST_TU;
      ST_TU:    state_next = ST_W1;
      ST_W1:    state_next = ST_W2;
      ST_W2:    state_next = ST_W3;
      ST_W3:    state_next = ST_X1;
      ST_X1:    state_next = ST_X2;
      ST_X2:    state_next = ST_X3;
      ST_X3:    state_next = ST_Y1;
      ST_Y1:    state_next = ST_Y2;
      ST_Y2:    state_next = ST_Y3;
      ST_Y3:    state_next = ST_SUM;
      ST_SUM:   state_next = ST_OUT;
      ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a    = t_q;
    mul_b    = POS_W'(t_q);
    load_out = 1'b0;
    unique case (state)
      ST_TU: begin
        mul_b = POS_W'(u_q);
      end
      ST_W1: begin
        mul_a = tu3;
        mul_b = POS_W'(u_q);
      end
      ST_W2: begin
        mul_a = tu3;
      end
      ST_W3: begin
        mul_a = tt;
      end
      ST_X1: begin
        mul_a = w1;
        mul_b = rel_c1_x;
      end
      ST_X2: begin
        mul_a = w2;
        mul_b = rel_c2_x;
      end
      ST_X3: begin
        mul_a = w3;
        mul_b = rel_end_x;
      end
      ST_Y1: begin
        mul_a = w1;
        mul_b = rel_c1_y;
      end
      ST_Y2: begin
        mul_a = w2;
        mul_b = rel_c2_y;
      end
      ST_Y3: begin
        mul_a = w3;
        mul_b = rel_end_y;
      end
      ST_OUT: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Curve arithmetic; the multiplier product is consumed by exactly one register per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= item.op;
      t_q     <= (item.phase > T_ONE) ? T_ONE : item.phase;
      pos_x_q <= item.pos_x;
      pos_y_q <= item.pos_y;
    end
    unique case (state)
      ST_TT: tt  <= wt;
      ST_TU: tu3 <= PHASE_W'({wt, 1'b0}) + wt;
      ST_W1: w1  <= wt;
      ST_W2: w2  <= wt;
      ST_W3: w3  <= wt;
      ST_X1: acc_x <= ACC_W'(prod);
      ST_X2, ST_X3: acc_x <= acc_x + ACC_W'(prod);
      ST_Y1: acc_y <= ACC_W'(prod);
      ST_Y2, ST_Y3: acc_y <= acc_y + ACC_W'(prod);
      ST_SUM: begin
        res_x <= sat_pos(SAT_W'(origin_x) + SAT_W'(pt_x));
        res_y <= sat_pos(SAT_W'(origin_y) + SAT_W'(pt_y));
      end
      ST_START: begin
        res_x <= pos_x_q;
        res_y <= pos_y_q;
      end
      default: begin
      end
    endcase
  end

  // Path state that persists from one item to the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      last_x    <= '0;
      last_y    <= '0;
      rel_c1_x  <= '0;
      rel_c1_y  <= '0;
      rel_c2_x  <= '0;
      rel_c2_y  <= '0;
      rel_end_x <= '0;
      rel_end_y <= '0;
    end else begin
      if (state == ST_START) begin
        origin_x  <= pos_x_q;
        origin_y  <= pos_y_q;
        rel_c1_x  <= sat_pos(SAT_W'(cfg.c1_x) - SAT_W'(off_x));
        rel_c1_y  <= sat_pos(SAT_W'(cfg.c1_y) - SAT_W'(off_y));
        rel_c2_x  <= sat_pos(SAT_W'(cfg.c2_x) - SAT_W'(off_x));
        rel_c2_y  <= sat_pos(SAT_W'(cfg.c2_y) - SAT_W'(off_y));
        rel_end_x <= sat_pos(SAT_W'(cfg.end_x) - SAT_W'(off_x));
        rel_end_y <= sat_pos(SAT_W'(cfg.end_y) - SAT_W'(off_y));
      end else if (state == ST_TT) begin
        origin_x <= sat_pos(SAT_W'(origin_x) + SAT_W'(pos_x_q) - SAT_W'(last_x));
        origin_y <= sat_pos(SAT_W'(origin_y) + SAT_W'(pos_y_q) - SAT_W'(last_y));
      end
      if (load_out) begin
        last_x <= res_x;
        last_y <= res_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.out_x <= res_x;
      result.out_y <= res_y;
    end
  end

  `BPM_ASSERT_NEXT(a_accept_busy, accept, state != ST_IDLE, "accepted item left block idle")
  `BPM_ASSERT_SAME(a_result_from_out, $rose(result_valid), $past(state == ST_OUT), "result outside OUT")
  `BPM_ASSERT_NEXT(a_last_holds, state != ST_OUT, $stable(last_x) && $stable(last_y), "last moved early")
  `BPM_ASSERT_SAME(a_start_path, state == ST_START, op_q == OP_START, "start state on update item")

endmodule

// ===== tb/tb_bezier_path_mover.sv =====
`timescale 1ns / 1ps

module tb_bezier_path_mover;
  import bpm_pkg::*;

  localparam longint UNIT        = longint'(1) << T_FRAC_BITS;
  localparam int     CYCLE_LIMIT = 600000;
  localparam logic signed [POS_W-1:0] P_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] P_MIN = 24'sh800000;

  typedef struct {
    bpm_item_t item;
    bit        follow;
  } move_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  bpm_item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  bpm_result_t result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  move_req_t   pending_moves[$];
  bpm_result_t expected_positions[$];
  int          moves_queued = 0;
  int          positions_checked = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 30;
  int          stall_pct = 30;

  bpm_cfg_t                path_cfg = '0;
  logic signed [POS_W-1:0] org_x = '0, org_y = '0, prev_x = '0, prev_y = '0;
  logic signed [POS_W-1:0] rc1_x = '0, rc1_y = '0, rc2_x = '0, rc2_y = '0;
  logic signed [POS_W-1:0] rend_x = '0, rend_y = '0;

  bezier_path_mover i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  function automatic logic signed [POS_W-1:0] clip_pos(input longint v);
    if (v > longint'(P_MAX)) begin
      return P_MAX;
    end else if (v < longint'(P_MIN)) begin
      return P_MIN;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic longint curve_offset(input longint p1, input longint p2, input longint p3,
                                          input longint w1, input longint w2, input longint w3);
    longint acc;
    acc = w1 * p1 + w2 * p2 + w3 * p3 + (UNIT >> 1);
    return acc >>> T_FRAC_BITS;
  endfunction

  // Applies one accepted transfer to the mover state and returns the new position.
  function automatic bpm_result_t advance_mover(input bpm_item_t it);
    bpm_result_t r;
    longint      t, u, tt, tu, w1, w2, w3, ox, oy;
    if (it.op == OP_START) begin
      ox = path_cfg.absolute_mode ? longint'(it.pos_x) : 0;
      oy = path_cfg.absolute_mode ? longint'(it.pos_y) : 0;
      org_x  = it.pos_x;
      org_y  = it.pos_y;
      prev_x = it.pos_x;
      prev_y = it.pos_y;
      rc1_x  = clip_pos(longint'(path_cfg.c1_x) - ox);
      rc1_y  = clip_pos(longint'(path_cfg.c1_y) - oy);
      rc2_x  = clip_pos(longint'(path_cfg.c2_x) - ox);
      rc2_y  = clip_pos(longint'(path_cfg.c2_y) - oy);
      rend_x = clip_pos(longint'(path_cfg.end_x) - ox);
      rend_y = clip_pos(longint'(path_cfg.end_y) - oy);
    end else begin
      t = longint'(it.phase);
      if (t > UNIT) begin
        t = UNIT;
      end
      u  = UNIT - t;
      tt = (t * t) >> T_FRAC_BITS;
      tu = (t * u) >> T_FRAC_BITS;
      w1 = (3 * tu * u) >> T_FRAC_BITS;
      w2 = (3 * tu * t) >> T_FRAC_BITS;
      w3 = (tt * t) >> T_FRAC_BITS;
      org_x = clip_pos(longint'(org_x) + (longint'(it.pos_x) - longint'(prev_x)));
      org_y = clip_pos(longint'(org_y) + (longint'(it.pos_y) - longint'(prev_y)));
      prev_x = clip_pos(longint'(org_x) + curve_offset(rc1_x, rc2_x, rend_x, w1, w2, w3));
      prev_y = clip_pos(longint'(org_y) + curve_offset(rc1_y, rc2_y, rend_y, w1, w2, w3));
    end
    r.out_x = prev_x;
    r.out_y = prev_y;
    return r;
  endfunction

  always @(posedge clk) begin
    bpm_item_t next_item;
    logic      next_valid;
    move_req_t req;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      next_valid = item_valid;
      next_item  = item;
      if (item_valid && !item_stall) begin
        expected_positions.push_back(advance_mover(item));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_moves.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        req = pending_moves.pop_front();
        next_item = req.item;
        // A following update carries a small offset from the last position.
        if (req.follow) begin
          next_item.pos_x = prev_x + req.item.pos_x;
          next_item.pos_y = prev_y + req.item.pos_y;
        end
        next_valid = 1'b1;
      end
      item_valid <= next_valid;
      item       <= next_item;
    end
  end

  always @(posedge clk) begin
    bpm_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_positions.size() == 0) begin
          $error("result transfer with no expected position: x %0d y %0d",
                 result.out_x, result.out_y);
          error_count++;
        end else begin
          want = expected_positions.pop_front();
          if (result.out_x !== want.out_x) begin
            $error("out_x expected %0d actual %0d", want.out_x, result.out_x);
            error_count++;
          end
          if (result.out_y !== want.out_y) begin
            $error("out_y expected %0d actual %0d", want.out_y, result.out_y);
            error_count++;
          end
          positions_checked++;
        end
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL bezier_path_mover");
      $finish;
    end
  end

  task automatic write_reg(input bpm_reg_t idx, input logic signed [POS_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(32 - POS_W){value[POS_W-1]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_C1_X:     path_cfg.c1_x = value;
      REG_C1_Y:     path_cfg.c1_y = value;
      REG_C2_X:     path_cfg.c2_x = value;
      REG_C2_Y:     path_cfg.c2_y = value;
      REG_END_X:    path_cfg.end_x = value;
      REG_END_Y:    path_cfg.end_y = value;
      REG_ABS_MODE: path_cfg.absolute_mode = value[0];
      default:      ;
    endcase
  endtask

  task automatic load_path(input bpm_cfg_t c);
    write_reg(REG_C1_X, c.c1_x);
    write_reg(REG_C1_Y, c.c1_y);
    write_reg(REG_C2_X, c.c2_x);
    write_reg(REG_C2_Y, c.c2_y);
    write_reg(REG_END_X, c.end_x);
    write_reg(REG_END_Y, c.end_y);
    write_reg(REG_ABS_MODE, {{(POS_W - 1){1'b0}}, c.absolute_mode});
  endtask

  task automatic queue_move(input logic op, input logic [PHASE_W-1:0] phase,
                            input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] y, input bit follow);
    move_req_t req;
    req.item.op    = op;
    req.item.phase = phase;
    req.item.pos_x = x;
    req.item.pos_y = y;
    req.follow     = follow;
    pending_moves.push_back(req);
    moves_queued++;
  endtask

  task automatic wait_for_drain();
    while (positions_checked != moves_queued) begin
      @(posedge clk);
    end
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? P_MAX : P_MIN;
      1:       return POS_W'($urandom);
      default: return POS_W'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rand_nudge();
    if ($urandom_range(0, 1)) begin
      return '0;
    end
    return POS_W'(int'($urandom_range(0, 512)) - 256);
  endfunction

  // One path: usually a start, then updates that mostly follow the curve.
  task automatic queue_path();
    int  steps;
    int  ph;
    steps = $urandom_range(1, 12);
    if ($urandom_range(0, 7) != 0) begin
      queue_move(OP_START, PHASE_W'($urandom), rand_pos(), rand_pos(), 1'b0);
    end
    for (int k = 1; k <= steps; k++) begin
      ph = (k * int'(UNIT)) / steps + int'($urandom_range(0, 2048)) - 1024;
      if (ph < 0) begin
        ph = 0;
      end else if (ph > int'(UNIT)) begin
        ph = int'(UNIT);
      end
      if ($urandom_range(0, 9) == 0) begin
        ph = $urandom_range(0, (1 << PHASE_W) - 1);
      end
      if ($urandom_range(0, 4) == 0) begin
        queue_move(OP_UPDATE, PHASE_W'(ph), rand_pos(), rand_pos(), 1'b0);
      end else begin
        queue_move(OP_UPDATE, PHASE_W'(ph), rand_nudge(), rand_nudge(), 1'b1);
      end
    end
  endtask

  initial begin
    bpm_cfg_t c;
    int       mark;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    queue_move(OP_UPDATE, PHASE_W'(32768), 24'sd100, -24'sd100, 1'b0);
    queue_move(OP_UPDATE, T_ONE, '0, '0, 1'b1);
    queue_move(OP_UPDATE, '1, P_MAX, P_MIN, 1'b0);
    queue_move(OP_START, '0, P_MAX, P_MIN, 1'b0);
    queue_move(OP_UPDATE, '0, '0, '0, 1'b1);
    wait_for_drain();

    c = '{c1_x: P_MAX, c1_y: P_MIN, c2_x: P_MIN, c2_y: P_MAX,
          end_x: P_MAX, end_y: P_MIN, absolute_mode: 1'b1};
    load_path(c);
    queue_move(OP_START, '1, P_MIN, P_MAX, 1'b0);
    queue_move(OP_UPDATE, PHASE_W'(16384), '0, '0, 1'b1);
    queue_move(OP_UPDATE, PHASE_W'(32768), '0, '0, 1'b1);
    queue_move(OP_UPDATE, T_ONE, '0, '0, 1'b1);
    queue_move(OP_UPDATE, PHASE_W'(70000), '0, '0, 1'b1);
    queue_move(OP_START, '0, '0, '0, 1'b0);
    queue_move(OP_UPDATE, PHASE_W'(49152), P_MAX, P_MAX, 1'b0);
    queue_move(OP_UPDATE, T_ONE, P_MIN, P_MIN, 1'b0);
    wait_for_drain();

    c = '{c1_x: P_MAX, c1_y: P_MAX, c2_x: P_MAX, c2_y: P_MIN,
          end_x: P_MAX, end_y: P_MIN, absolute_mode: 1'b0};
    load_path(c);
    queue_move(OP_START, '0, 24'sh7FF000, 24'sh801000, 1'b0);
    queue_move(OP_UPDATE, PHASE_W'(32768), '0, '0, 1'b1);
    queue_move(OP_UPDATE, T_ONE, '0, '0, 1'b1);
    queue_move(OP_UPDATE, '1, 24'sd256, -24'sd256, 1'b1);
    wait_for_drain();

    for (int phase_no = 0; phase_no < 8; phase_no++) begin
      c.c1_x  = rand_pos();
      c.c1_y  = rand_pos();
      c.c2_x  = rand_pos();
      c.c2_y  = rand_pos();
      c.end_x = rand_pos();
      c.end_y = rand_pos();
      c.absolute_mode = 1'($urandom_range(0, 1));
      idle_pct  = (phase_no == 3) ? 0 : 30;
      stall_pct = (phase_no == 3) ? 0 : 30;
      load_path(c);
      // Updates ahead of the first start still use the previous path.
      queue_move(OP_UPDATE, PHASE_W'($urandom_range(0, int'(UNIT))), '0, '0, 1'b1);
      queue_move(OP_UPDATE, T_ONE, rand_nudge(), rand_nudge(), 1'b1);
      mark = moves_queued;
      while (moves_queued - mark < 125) begin
        queue_path();
      end
      wait_for_drain();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_positions.size() == 0) begin
      $display("PASS bezier_path_mover");
    end else begin
      $display("FAIL bezier_path_mover");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bpm_pkg.sv
hw/rtl/bpm_apb_regs.sv
hw/rtl/bezier_path_mover.sv
tb/tb_bezier_path_mover.sv
